@@ sv/i2c_reg_pkg.sv @@
package i2c_reg_pkg;

  localparam int DelayW = 18;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] MODE_MSB  = 2'd0;
  localparam logic [1:0] MODE_LSB  = 2'd1;
  localparam logic [1:0] MODE_LITE = 2'd2;

  localparam logic [1:0] REG_DEV_ADDR  = 2'd0;
  localparam logic [1:0] REG_BYTE_MODE = 2'd1;
  localparam logic [1:0] REG_TICKS_US  = 2'd2;
  localparam logic [1:0] REG_POLL_LIM  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] reg_addr;
    logic [15:0] write_value;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic        scl_level;
    logic        scl_enable;
    logic        sda_level;
    logic        sda_enable;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_value;
  } out_item_t;

  function automatic logic [15:0] swap16(input logic [15:0] x);
    return {x[7:0], x[15:8]};
  endfunction

endpackage

@@ sv/i2c_reg_if.sv @@
interface i2c_reg_in_if;
  logic                 valid;
  logic                 ready;
  i2c_reg_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface i2c_reg_out_if;
  logic                  valid;
  logic                  ready;
  i2c_reg_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/i2c_master_reg16_access_core.sv @@
// Channel   | Dir | Payload                                          | Handshake
// in_       | in  | command, reg_addr, write_value, sda_in           | valid/ready
// out_      | out | scl/sda level+enable, busy, done, read_value     | valid/ready
// cfg_      | in  | APB: 4 registers at byte addresses 0,4,8,12      | psel/penable
//
// One tick per cycle while input is valid and not stalled: each accepted
// input advances the sequencer by one tick and yields one output transaction;
// the next-state logic is one counter decrement or one sequencing step between
// state and result register. Reset (rst_n low, synchronous) idles the sequencer
// and releases both pins. A held result stalls input only when the output
// register is full and not being taken; otherwise the input is ready every cycle.
module i2c_master_reg16_access_core (
  input  logic                clk,
  input  logic                rst_n,
  i2c_reg_in_if.sink          in_ch,
  i2c_reg_out_if.source       out_ch,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import i2c_reg_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_WB_LOW, PH_WB_HIGH, PH_WB_END, PH_WA_REL,
    PH_WA_POLL, PH_WA_LOW, PH_RB_PRE, PH_RB_REL, PH_RB_HIGH, PH_RB_SAMPLE,
    PH_RB_LOW, PH_RB_ACK1, PH_RB_ACK2, PH_RB_ACK3, PH_WDELAY, PH_SP_A,
    PH_SP_B, PH_SP_C, PH_RDELAY, PH_FINISH
  } phase_t;

  // configuration registers
  logic [6:0]  dev_addr_r;
  logic [1:0]  mode_r;
  logic [10:0] tpu_r;
  logic [7:0]  poll_lim_r;

  // sequencer state
  phase_t      phase_r, phase_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic [2:0]  byte_idx_r, byte_idx_nxt;
  logic [DelayW-1:0] delay_r, delay_nxt;
  logic [7:0]  shift_r, shift_nxt, hi_r, hi_nxt, lo_r, lo_nxt, poll_r, poll_nxt;
  logic [15:0] haddr_r, haddr_nxt, hval_r, hval_nxt;
  logic        is_read_r, is_read_nxt;
  logic        scl_lv_r, scl_lv_nxt, scl_en_r, scl_en_nxt;
  logic        sda_lv_r, sda_lv_nxt, sda_en_r, sda_en_nxt;

  logic        out_valid_r;
  out_item_t   out_data_r, res_nxt;
  logic        take;

  assign cfg_pready   = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign take         = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_DEV_ADDR:  cfg_prdata = {25'd0, dev_addr_r};
      REG_BYTE_MODE: cfg_prdata = {30'd0, mode_r};
      REG_TICKS_US:  cfg_prdata = {21'd0, tpu_r};
      REG_POLL_LIM:  cfg_prdata = {24'd0, poll_lim_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // delay of n microseconds minus one; n fits in 7 bits, ticks in 11
  logic [10:0] tpu_eff;
  assign tpu_eff = (tpu_r == 11'd0) ? 11'd1 : tpu_r;
  function automatic logic [DelayW-1:0] hold_us(input logic [6:0] us,
                                                input logic [10:0] t);
    logic [DelayW-1:0] p;
    p = DelayW'(us) * DelayW'(t);
    return p - DelayW'(1);
  endfunction

  logic [7:0] tx_byte;
  logic [7:0] dev_w;
  always_comb begin
    dev_w = {dev_addr_r, 1'b0};
    if (byte_idx_nxt == 3'd0)      tx_byte = dev_w | {7'd0, is_read_nxt && mode_r == MODE_LITE};
    else if (byte_idx_nxt == 3'd1) tx_byte = haddr_nxt[15:8];
    else if (byte_idx_nxt == 3'd2) tx_byte = haddr_nxt[7:0];
    else if (is_read_nxt)          tx_byte = dev_w | 8'd1;
    else if (byte_idx_nxt == 3'd3) tx_byte = hval_nxt[15:8];
    else                           tx_byte = hval_nxt[7:0];
  end

  logic do_act, done;
  logic [3:0] bc_dec;
  always_comb begin
    phase_nxt = phase_r; bit_cnt_nxt = bit_cnt_r; byte_idx_nxt = byte_idx_r;
    delay_nxt = delay_r; shift_nxt = shift_r; hi_nxt = hi_r; lo_nxt = lo_r;
    poll_nxt = poll_r; haddr_nxt = haddr_r; hval_nxt = hval_r;
    is_read_nxt = is_read_r; scl_lv_nxt = scl_lv_r; scl_en_nxt = scl_en_r;
    sda_lv_nxt = sda_lv_r; sda_en_nxt = sda_en_r;
    done = 1'b0; do_act = 1'b0; bc_dec = bit_cnt_r - 4'd1;
    // latch a new command
    if (phase_r == PH_IDLE) begin
      if (in_ch.data.command == CMD_WRITE || in_ch.data.command == CMD_READ) begin
        is_read_nxt  = (in_ch.data.command == CMD_READ);
        haddr_nxt    = (mode_r == MODE_LITE) ? swap16(in_ch.data.reg_addr)
                                             : in_ch.data.reg_addr;
        hval_nxt     = 16'd0;
        if (!is_read_nxt)
          hval_nxt = (mode_r == MODE_LSB || mode_r == MODE_LITE)
                     ? swap16(in_ch.data.write_value) : in_ch.data.write_value;
        byte_idx_nxt = 3'd0; hi_nxt = 8'd0; lo_nxt = 8'd0;
        phase_nxt    = PH_ST_A;
        do_act       = 1'b1;
      end
    end else if (delay_r != '0) begin
      delay_nxt = delay_r - DelayW'(1);
    end else begin
      do_act = 1'b1;
    end
    // one sequencing step; PH_ST_B / PH_WA_LOW begin a byte from tx_byte
    if (do_act) begin
      case (phase_nxt)
        PH_ST_A: begin
          scl_en_nxt = 1'b1; sda_en_nxt = 1'b1; sda_lv_nxt = 1'b1; scl_lv_nxt = 1'b1;
          delay_nxt = hold_us(7'd1, tpu_eff); phase_nxt = PH_ST_B;
        end
        PH_ST_B: begin
          sda_lv_nxt = 1'b0; delay_nxt = hold_us(7'd1, tpu_eff);
          shift_nxt = tx_byte; bit_cnt_nxt = 4'd8; phase_nxt = PH_WB_LOW;
        end
        PH_WB_LOW: begin
          scl_en_nxt = 1'b1; sda_en_nxt = 1'b1; scl_lv_nxt = 1'b0;
          delay_nxt = hold_us(7'd1, tpu_eff); phase_nxt = PH_WB_HIGH;
        end
        PH_WB_HIGH: begin
          sda_lv_nxt = shift_r[7]; scl_lv_nxt = 1'b1;
          delay_nxt = hold_us(7'd1, tpu_eff);
          shift_nxt = {shift_r[6:0], 1'b0}; bit_cnt_nxt = bc_dec;
          phase_nxt = (bc_dec != 4'd0) ? PH_WB_LOW : PH_WB_END;
        end
        PH_WB_END: begin
          scl_lv_nxt = 1'b0; delay_nxt = hold_us(7'd1, tpu_eff); phase_nxt = PH_WA_REL;
        end
        PH_WA_REL: begin
          sda_en_nxt = 1'b0; scl_lv_nxt = 1'b1; delay_nxt = hold_us(7'd1, tpu_eff);
          poll_nxt = 8'd0; phase_nxt = PH_WA_POLL;
        end
        PH_WA_POLL: begin
          if (in_ch.data.sda_in && poll_r < poll_lim_r) begin
            poll_nxt = poll_r + 8'd1; delay_nxt = '0;
          end else begin
            delay_nxt = hold_us(7'd2, tpu_eff); phase_nxt = PH_WA_LOW;
          end
        end
        PH_WA_LOW: begin
          scl_lv_nxt = 1'b0; delay_nxt = hold_us(7'd2, tpu_eff);
          if (!is_read_r) begin
            if (byte_idx_r < 3'd4) begin
              byte_idx_nxt = byte_idx_r + 3'd1; phase_nxt = PH_WB_LOW;
            end else begin
              phase_nxt = PH_WDELAY;
            end
          end else if (byte_idx_r < 3'd2) begin
            byte_idx_nxt = byte_idx_r + 3'd1; phase_nxt = PH_WB_LOW;
          end else if (byte_idx_r == 3'd2 && mode_r != MODE_LITE) begin
            byte_idx_nxt = 3'd3; phase_nxt = PH_SP_A;
          end else begin
            byte_idx_nxt = 3'd4; phase_nxt = PH_RB_PRE;
          end
          if (phase_nxt == PH_WB_LOW) begin
            shift_nxt = tx_byte; bit_cnt_nxt = 4'd8;
          end
        end
        PH_RB_PRE: begin
          delay_nxt = hold_us(7'd1, tpu_eff); shift_nxt = 8'd0; bit_cnt_nxt = 4'd8;
          phase_nxt = PH_RB_REL;
        end
        PH_RB_REL: begin
          sda_en_nxt = 1'b0; delay_nxt = hold_us(7'd1, tpu_eff); phase_nxt = PH_RB_HIGH;
        end
        PH_RB_HIGH: begin
          scl_lv_nxt = 1'b1; delay_nxt = hold_us(7'd1, tpu_eff); phase_nxt = PH_RB_SAMPLE;
        end
        PH_RB_SAMPLE: begin
          shift_nxt = {shift_r[6:0], in_ch.data.sda_in};
          delay_nxt = hold_us(7'd1, tpu_eff); phase_nxt = PH_RB_LOW;
        end
        PH_RB_LOW: begin
          scl_lv_nxt = 1'b0; delay_nxt = hold_us(7'd1, tpu_eff); bit_cnt_nxt = bc_dec;
          phase_nxt = (bc_dec != 4'd0) ? PH_RB_HIGH : PH_RB_ACK1;
        end
        PH_RB_ACK1: begin
          sda_en_nxt = 1'b1; scl_lv_nxt = 1'b0; sda_lv_nxt = (byte_idx_r != 3'd4);
          delay_nxt = hold_us(7'd1, tpu_eff); phase_nxt = PH_RB_ACK2;
        end
        PH_RB_ACK2: begin
          scl_lv_nxt = 1'b1; delay_nxt = hold_us(7'd1, tpu_eff); phase_nxt = PH_RB_ACK3;
        end
        PH_RB_ACK3: begin
          scl_lv_nxt = 1'b0; delay_nxt = hold_us(7'd1, tpu_eff);
          if (byte_idx_r == 3'd4) begin
            hi_nxt = shift_r; byte_idx_nxt = 3'd5; phase_nxt = PH_RB_PRE;
          end else begin
            lo_nxt = shift_r; phase_nxt = PH_SP_A;
          end
        end
        PH_WDELAY: begin
          delay_nxt = hold_us(7'd100, tpu_eff); phase_nxt = PH_SP_A;
        end
        PH_SP_A: begin
          sda_en_nxt = 1'b1; scl_lv_nxt = 1'b0; sda_lv_nxt = 1'b0;
          delay_nxt = hold_us(7'd1, tpu_eff); phase_nxt = PH_SP_B;
        end
        PH_SP_B: begin
          scl_lv_nxt = 1'b1; delay_nxt = hold_us(7'd1, tpu_eff); phase_nxt = PH_SP_C;
        end
        PH_SP_C: begin
          sda_lv_nxt = 1'b1; delay_nxt = hold_us(7'd10, tpu_eff);
          phase_nxt = (is_read_r && byte_idx_r == 3'd3) ? PH_RDELAY : PH_FINISH;
        end
        PH_RDELAY: begin
          sda_en_nxt = 1'b0; scl_en_nxt = 1'b0; delay_nxt = hold_us(7'd5, tpu_eff);
          phase_nxt = PH_ST_A;
        end
        PH_FINISH: begin
          sda_en_nxt = 1'b0; scl_en_nxt = 1'b0; delay_nxt = '0;
          done = 1'b1; phase_nxt = PH_IDLE;
        end
        default: begin
          sda_en_nxt = 1'b0; scl_en_nxt = 1'b0; delay_nxt = '0; phase_nxt = PH_IDLE;
        end
      endcase
    end
    res_nxt.scl_level  = scl_lv_nxt;
    res_nxt.scl_enable = scl_en_nxt;
    res_nxt.sda_level  = sda_lv_nxt;
    res_nxt.sda_enable = sda_en_nxt;
    res_nxt.busy_res   = (phase_nxt != PH_IDLE);
    res_nxt.done_res   = done;
    res_nxt.read_value = 16'd0;
    if (done && is_read_nxt)
      res_nxt.read_value = (mode_r == MODE_MSB) ? {hi_nxt, lo_nxt} : {lo_nxt, hi_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 7'd0; mode_r <= MODE_MSB; tpu_r <= 11'd1; poll_lim_r <= 8'd100;
      phase_r <= PH_IDLE; bit_cnt_r <= 4'd0; byte_idx_r <= 3'd0; delay_r <= '0;
      shift_r <= 8'd0; hi_r <= 8'd0; lo_r <= 8'd0; poll_r <= 8'd0;
      haddr_r <= 16'd0; hval_r <= 16'd0; is_read_r <= 1'b0;
      scl_lv_r <= 1'b0; scl_en_r <= 1'b0; sda_lv_r <= 1'b0; sda_en_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_DEV_ADDR:  dev_addr_r <= cfg_pwdata[6:0];
          REG_BYTE_MODE: mode_r     <= cfg_pwdata[1:0];
          REG_TICKS_US:  tpu_r      <= cfg_pwdata[10:0];
          REG_POLL_LIM:  poll_lim_r <= cfg_pwdata[7:0];
          default: ;
        endcase
      end
      // advance one tick per accepted input transaction
      if (take) begin
        phase_r <= phase_nxt; bit_cnt_r <= bit_cnt_nxt; byte_idx_r <= byte_idx_nxt;
        delay_r <= delay_nxt; shift_r <= shift_nxt; hi_r <= hi_nxt; lo_r <= lo_nxt;
        poll_r <= poll_nxt; haddr_r <= haddr_nxt; hval_r <= hval_nxt;
        is_read_r <= is_read_nxt; scl_lv_r <= scl_lv_nxt; scl_en_r <= scl_en_nxt;
        sda_lv_r <= sda_lv_nxt; sda_en_r <= sda_en_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_data_r <= res_nxt;
  end

  // done only ever reported with the sequencer back in idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res && phase_r == PH_IDLE)
    else $error("done while busy");
  // a held result may not be overwritten
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(out_data_r))
    else $error("result lost");
  // busy in the output mirrors the sequencer phase
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(take) |-> out_data_r.busy_res == (phase_r != PH_IDLE))
    else $error("busy mismatch");
endmodule
